FILE: sv/lrupr_pkg.sv
// lrupr_pkg: shared types and constants for the LRU page replacement unit.
// No dependencies; imported by lrupr_cell and lru_page_replacement_unit.
package lrupr_pkg;

    localparam int unsigned CAP_W = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic clear;    // capacity write: empty the store
        logic access;   // input transfer this cycle
        logic full;     // occupancy has reached effective capacity
    } cell_ctl_t;

endpackage

FILE: sv/lrupr_cell.sv
// lrupr_cell: one recency position of the LRU store, key plus valid bit.
// Depends on lrupr_pkg; chained by lru_page_replacement_unit.
module lrupr_cell #(
    parameter int unsigned KEY_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lrupr_pkg::cell_ctl_t   ctl,
    input  logic [KEY_BITS-1:0]    lookup_key,
    input  logic [KEY_BITS-1:0]    prev_key,
    input  logic                   prev_valid,
    input  logic                   seen_in,
    output logic [KEY_BITS-1:0]    key_out,
    output logic                   valid_out,
    output logic                   seen_out
);
    import lrupr_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic                valid_reg;
    logic                valid_next;
    logic                match;
    logic                shift;

    assign match    = valid_reg && (key_reg == lookup_key);
    assign seen_out = seen_in | match;
    // take the younger neighbor's key up to and including the hit position,
    // or up to the fill point / tail on a miss
    assign shift    = ctl.access && !seen_in && (valid_reg || (!ctl.full && prev_valid));

    always_comb
    begin
        valid_next = valid_reg;
        priority if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift && !ctl.clear)
        begin
            key_reg <= prev_key;
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;

endmodule

FILE: sv/lru_page_replacement_unit.sv
// lru_page_replacement_unit: fully associative page store with LRU replacement.
// Depends on lrupr_pkg and lrupr_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one page_key per transfer.
//   Output channel (out_valid / out_stall) returns one result per input:
//   was_hit, evict_valid, evicted_key, hit_total, miss_total, occupancy.
//   The store is a row of MAX_ENTRIES cells ordered most recent first; a
//   lookup compares all cells and the row shifts by one toward the old end
//   in the same cycle.
//   The result is registered and is valid the cycle after the input transfer.
//   Throughput: one item per cycle while the receiver takes results.
//   in_stall rises only when the output register holds a result the
//   receiver is stalling; it then holds the result unchanged.
//   Configuration: cfg_write_en with cfg_write_data sets the capacity
//   (0 acts as 1, above MAX_ENTRIES acts as MAX_ENTRIES) and empties the
//   store and both counts. Write only while idle.
//   Reset: store empty, counts zero, capacity 8, no result pending.
module lru_page_replacement_unit #(
    parameter int unsigned MAX_ENTRIES = 8,
    parameter int unsigned KEY_BITS    = 16,
    parameter int unsigned COUNT_BITS  = 32,
    localparam int unsigned OCC_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [lrupr_pkg::CAP_W-1:0]  cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KEY_BITS-1:0]          page_key,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         was_hit,
    output logic                         evict_valid,
    output logic [KEY_BITS-1:0]          evicted_key,
    output logic [COUNT_BITS-1:0]        hit_total,
    output logic [COUNT_BITS-1:0]        miss_total,
    output logic [OCC_W-1:0]             occupancy
);
    import lrupr_pkg::*;

    localparam int unsigned CW = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0]       cap_reg;
    logic [OCC_W-1:0]       count_reg;
    logic [OCC_W-1:0]       count_next;
    logic [COUNT_BITS-1:0]  hits_reg;
    logic [COUNT_BITS-1:0]  hits_next;
    logic [COUNT_BITS-1:0]  misses_reg;
    logic [COUNT_BITS-1:0]  misses_next;

    logic                   out_valid_reg;
    logic                   was_hit_reg;
    logic                   evict_valid_reg;
    logic [KEY_BITS-1:0]    evicted_key_reg;
    logic [COUNT_BITS-1:0]  hit_total_reg;
    logic [COUNT_BITS-1:0]  miss_total_reg;
    logic [OCC_W-1:0]       occupancy_reg;

    logic [CW-1:0]          cap_ext;
    logic [CW-1:0]          cap_eff;
    logic                   full;
    logic                   in_xfer;
    logic                   hit;
    logic                   evict;
    logic [KEY_BITS-1:0]    evicted;
    cell_ctl_t              ctl;

    logic [KEY_BITS-1:0]    link_key   [0:MAX_ENTRIES];
    logic                   link_valid [0:MAX_ENTRIES];
    logic                   link_seen  [0:MAX_ENTRIES];
    logic [MAX_ENTRIES:0]   valid_ext;
    logic [MAX_ENTRIES-1:0] tail;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign cap_ext = CW'(cap_reg);
    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cap_ext > CW'(MAX_ENTRIES))
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign full       = CW'(count_reg) >= cap_eff;
    assign ctl.clear  = cfg_write_en;
    assign ctl.access = in_xfer;
    assign ctl.full   = full;

    assign link_key[0]   = page_key;
    assign link_valid[0] = 1'b1;
    assign link_seen[0]  = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lrupr_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .lookup_key (page_key),
            .prev_key   (link_key[i]),
            .prev_valid (link_valid[i]),
            .seen_in    (link_seen[i]),
            .key_out    (link_key[i+1]),
            .valid_out  (link_valid[i+1]),
            .seen_out   (link_seen[i+1])
        );
        assign valid_ext[i] = link_valid[i+1];
    end
    assign valid_ext[MAX_ENTRIES] = 1'b0;

    assign hit   = link_seen[MAX_ENTRIES];
    assign evict = !hit && full && (count_reg != '0);

    always_comb
    begin
        evicted = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tail[i] = valid_ext[i] && !valid_ext[i+1];
            evicted = evicted | ({KEY_BITS{tail[i]}} & link_key[i+1]);
        end
    end

    always_comb
    begin
        hits_next   = (hit && !(&hits_reg)) ? hits_reg + 1'b1 : hits_reg;
        misses_next = (!hit && !(&misses_reg)) ? misses_reg + 1'b1 : misses_reg;
        count_next  = (!hit && !full) ? count_reg + 1'b1 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg    <= cfg_write_data;
                count_reg  <= '0;
                hits_reg   <= '0;
                misses_reg <= '0;
            end
            else if (in_xfer)
            begin
                count_reg  <= count_next;
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
            end
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            was_hit_reg     <= hit;
            evict_valid_reg <= evict;
            evicted_key_reg <= evict ? evicted : '0;
            hit_total_reg   <= hits_next;
            miss_total_reg  <= misses_next;
            occupancy_reg   <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign was_hit     = was_hit_reg;
    assign evict_valid = evict_valid_reg;
    assign evicted_key = evicted_key_reg;
    assign hit_total   = hit_total_reg;
    assign miss_total  = miss_total_reg;
    assign occupancy   = occupancy_reg;

    a_count_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_ext) == count_reg)
        else $error("occupancy count disagrees with cell valid bits");

    a_count_within_cap : assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= cap_eff)
        else $error("occupancy above effective capacity");

    a_hit_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && hit && !cfg_write_en) |=> (count_reg == $past(count_reg)))
        else $error("hit changed occupancy");

    a_no_evict_on_hit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(was_hit_reg && evict_valid_reg))
        else $error("eviction reported on a hit");

endmodule
